// ----- src/scag_pkg.sv -----
`default_nettype none

package scag_pkg;

    // Field and register widths.
    localparam int COORD_W = 8;
    localparam int SIDE_W  = 9;
    localparam int ALPHA_W = 8;

    // Largest sprite side; wider writes saturate to it.
    localparam logic [SIDE_W-1:0] MAX_SIDE   = 9'd256;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd64;

    // Offset magnitude |2x+1-S|, its square and the sum of both squares.
    localparam int DIFF_W = COORD_W + 3;
    localparam int ERR_W  = COORD_W + 1;
    localparam int SQ_W   = 2 * ERR_W;
    localparam int SUM_W  = SQ_W + 1;

    // Square root of the sum shifted up by 32 bits, one root bit per stage.
    localparam int RAD_W  = SUM_W + 1;
    localparam int ROOT_W = (SUM_W + 33) / 2;
    localparam int REM_W  = ROOT_W + 2;

    // Distance in Q16 and the smoothstep arithmetic.
    localparam int Q_W   = 16;
    localparam int T_W   = Q_W + 1;
    localparam int TT_W  = 2 * Q_W + 1;
    localparam int TW_W  = Q_W + 2;
    localparam int P_W   = TT_W + TW_W;
    localparam int ACC_W = T_W + 8;

    localparam logic [T_W-1:0]   Q16_ONE      = 17'd65536;
    localparam logic [TW_W-1:0]  SMOOTH_THREE = 18'd196608;
    localparam logic [ACC_W-1:0] ROUND_HALF   = 25'd32768;

endpackage

`default_nettype wire

// ----- src/soft_circle_alpha_generator_core.sv -----
// Soft disc alpha generator, one texel per request, fully pipelined.
// o_strobe follows the front end, root, quotient and smoothstep registers.
// Throughput: one request per cycle; busy is always low. Most of the depth is
// in the 26-stage square root and the 16-stage quotient pipeline.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, active low) clears all valid bits and sets the side to 64.
`default_nettype none

module soft_circle_alpha_generator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [scag_pkg::COORD_W-1:0]    i_pixel_x,
    input  wire logic [scag_pkg::COORD_W-1:0]    i_pixel_y,
    output logic                                 o_strobe,
    output logic      [scag_pkg::ALPHA_W-1:0]    o_alpha,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [scag_pkg::SIDE_W-1:0]     i_cfg_data
);
    import scag_pkg::*;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] r_tex_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_size <= SIDE_RESET;
        end else if (i_cfg_valid) begin
            r_tex_size <= (i_cfg_data > MAX_SIDE) ? MAX_SIDE : i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // ---------------------------------------------------------------
    // Front end: offsets from the center, their squares and their sum
    // ---------------------------------------------------------------
    logic [DIFF_W-1:0] n_dx, n_dy;
    logic [ERR_W-1:0]  n_ax, n_ay;
    logic [ERR_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic              r_vld_in, r_vld_sq;

    always_comb begin
        n_dx = {2'b00, i_pixel_x, 1'b1} - {2'b00, r_tex_size};
        n_dy = {2'b00, i_pixel_y, 1'b1} - {2'b00, r_tex_size};
        n_ax = n_dx[DIFF_W-1] ? ERR_W'(-n_dx) : n_dx[ERR_W-1:0];
        n_ay = n_dy[DIFF_W-1] ? ERR_W'(-n_dy) : n_dy[ERR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
            r_vld_sq <= 1'b0;
        end else begin
            r_vld_in <= start;
            r_vld_sq <= r_vld_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
    end

    // ---------------------------------------------------------------
    // Square root of (sum << 32), one root bit per stage
    // ---------------------------------------------------------------
    logic [RAD_W-1:0]  r_rt_rad  [0:ROOT_W];
    logic [ROOT_W-1:0] r_rt_root [0:ROOT_W];
    logic [REM_W-1:0]  r_rt_rem  [0:ROOT_W];
    logic              r_rt_vld  [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else begin
            r_rt_vld[0] <= r_vld_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt_rad[0]  <= {1'b0, {1'b0, r_sqx} + {1'b0, r_sqy}};
        r_rt_root[0] <= '0;
        r_rt_rem[0]  <= '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0] n_shift;
        logic [REM_W-1:0] n_trial;
        logic             n_take;

        // Once the sum has been shifted out, the remaining radicand pairs are zero.
        always_comb begin
            n_shift = {r_rt_rem[k][REM_W-3:0], r_rt_rad[k][RAD_W-1 -: 2]};
            n_trial = {r_rt_root[k], 2'b01};
            n_take  = (n_shift >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[k+1] <= 1'b0;
            end else begin
                r_rt_vld[k+1] <= r_rt_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rt_rad[k+1]  <= {r_rt_rad[k][RAD_W-3:0], 2'b00};
            r_rt_root[k+1] <= {r_rt_root[k][ROOT_W-2:0], n_take};
            r_rt_rem[k+1]  <= n_take ? (n_shift - n_trial) : n_shift;
        end
    end

    // ---------------------------------------------------------------
    // Distance in Q16: root / side, one quotient bit per stage.
    // A root at or above side << 16 means the texel lies on or past the rim.
    // ---------------------------------------------------------------
    logic [ROOT_W-1:0] r_dv_rem [0:Q_W];
    logic [Q_W-1:0]    r_dv_q   [0:Q_W];
    logic              r_dv_ovf [0:Q_W];
    logic              r_dv_vld [0:Q_W];
    logic [ROOT_W-1:0] n_side_top;

    assign n_side_top = ROOT_W'({r_tex_size, Q_W'(0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_rt_vld[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= r_rt_root[ROOT_W];
        r_dv_q[0]   <= '0;
        r_dv_ovf[0] <= (r_rt_root[ROOT_W] >= n_side_top);
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int BIT = Q_W - 1 - j;
        logic [ROOT_W-1:0] n_dsub;
        logic              n_dtake;

        always_comb begin
            n_dsub  = ROOT_W'(r_tex_size) << BIT;
            n_dtake = (r_dv_rem[j] >= n_dsub);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[j+1] <= n_dtake ? (r_dv_rem[j] - n_dsub) : r_dv_rem[j];
            r_dv_ovf[j+1] <= r_dv_ovf[j];
            if (n_dtake) begin
                r_dv_q[j+1] <= r_dv_q[j] | (Q_W'(1) << BIT);
            end else begin
                r_dv_q[j+1] <= r_dv_q[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // Smoothstep t*t*(3 - 2t) and scaling to 0..255.
    // A zero side always overflows the quotient, so it ends in alpha 0.
    // ---------------------------------------------------------------
    logic [T_W-1:0]   r_t;
    logic [TT_W-1:0]  r_tt;
    logic [TW_W-1:0]  r_tw;
    logic [P_W-1:0]   r_p;
    logic [T_W-1:0]   r_a;
    logic [ACC_W-1:0] n_acc;
    logic             r_vld_t, r_vld_tt, r_vld_p, r_vld_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_t  <= 1'b0;
            r_vld_tt <= 1'b0;
            r_vld_p  <= 1'b0;
            r_vld_a  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_vld_t  <= r_dv_vld[Q_W];
            r_vld_tt <= r_vld_t;
            r_vld_p  <= r_vld_tt;
            r_vld_a  <= r_vld_p;
            o_strobe <= r_vld_a;
        end
    end

    always_comb begin
        n_acc = ({r_a, 8'b0} - ACC_W'(r_a)) + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        r_t     <= r_dv_ovf[Q_W] ? '0 : (Q16_ONE - {1'b0, r_dv_q[Q_W]});
        r_tt    <= TT_W'(r_t * r_t);
        r_tw    <= SMOOTH_THREE - {r_t, 1'b0};
        r_p     <= r_tt * r_tw;
        r_a     <= r_p[32 +: T_W];
        o_alpha <= n_acc[Q_W +: ALPHA_W];
    end

endmodule

`default_nettype wire
